// ===== src/sclr_pkg.sv =====
// ----------------------------------------------------------------------------
// sclr_pkg
// Shared types and constants for the cubic sensor linearisation and rate block.
// ----------------------------------------------------------------------------
`default_nettype none

package sclr_pkg;

	// field and register widths
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int COEF_W          = 64;
	localparam int TPS_W           = 27;
	localparam int TICK_W          = 32;
	localparam int TEMP_W          = 32;
	localparam int CFG_IDX_W       = 3;

	// polynomial accumulator: four 32-bit limbs, handled one limb a cycle
	localparam int LIMB_W   = 32;
	localparam int ACC_W    = 128;
	localparam int LIMB_CW  = 2;
	localparam int STEP_CW  = 2;

	// rate datapath
	localparam int MAG_W     = 32;
	localparam int PROD_W    = MAG_W + TPS_W;
	localparam int DIV_W     = ((PROD_W + 1) / 2) * 2;
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ZERO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_THREE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TPS        = 3'd4;

	localparam logic [TPS_W-1:0] TPS_RESET = 27'd1000;

	// Horner steps: which coefficient is added in each pass
	localparam logic [STEP_CW-1:0] POLY_STEP_SQUARE = 2'd0;
	localparam logic [STEP_CW-1:0] POLY_STEP_LINEAR = 2'd1;
	localparam logic [STEP_CW-1:0] POLY_STEP_CONST  = 2'd2;

	localparam logic [LIMB_CW-1:0] LIMB_LAST = 2'd3;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	// saturation limits
	localparam logic [TEMP_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [TEMP_W-1:0] SAT_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POLY,
		ST_SAT,
		ST_DIFF,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} sclr_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic                load;
		logic                poly;
		logic [LIMB_CW-1:0]  limb;
		logic [STEP_CW-1:0]  step;
		logic                sat;
		logic                diff;
		logic                mul;
		logic                div;
		logic                finish;
	} sclr_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic tick_differs;
	} sclr_status_t;

endpackage

`default_nettype wire

// ===== src/sclr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sclr_ctrl
// Sequencer: Horner passes, temperature saturation, rate multiply and divide.
// ----------------------------------------------------------------------------
`default_nettype none

module sclr_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire                   out_free,
	input  sclr_pkg::sclr_status_t status,
	output sclr_pkg::sclr_cmd_t    cmd
);
	import sclr_pkg::*;

	sclr_state_t            state_q, state_d;
	logic [LIMB_CW-1:0]     limb_q, limb_d;
	logic [STEP_CW-1:0]     step_q, step_d;
	logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limb_q  <= '0;
			step_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			limb_q  <= limb_d;
			step_q  <= step_d;
			cnt_q   <= cnt_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		limb_d   = limb_q;
		step_d   = step_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.limb = limb_q;
		cmd.step = step_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					limb_d   = '0;
					step_d   = POLY_STEP_SQUARE;
					state_d  = ST_POLY;
				end
			end
			ST_POLY: begin
				cmd.poly = 1'b1;
				limb_d   = limb_q + 1'b1;
				if (limb_q == LIMB_LAST) begin
					step_d = step_q + 1'b1;
					if (step_q == POLY_STEP_CONST) begin
						state_d = ST_SAT;
					end
				end
			end
			ST_SAT: begin
				cmd.sat = 1'b1;
				state_d = status.tick_differs ? ST_DIFF : ST_DONE;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/sclr_dp.sv =====
// ----------------------------------------------------------------------------
// sclr_dp
// Datapath: limb-serial Horner evaluation, saturation, rate multiply and
// radix-4 restoring divider, plus the per-sample state.
// ----------------------------------------------------------------------------
`default_nettype none

module sclr_dp #(
	parameter int SAMPLE_BITS = sclr_pkg::SAMPLE_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  sclr_pkg::sclr_cmd_t            cmd,
	output sclr_pkg::sclr_status_t         status,
	input  wire [SAMPLE_BITS-1:0]          adc_sample,
	input  wire [sclr_pkg::TICK_W-1:0]     current_tick,
	input  wire [sclr_pkg::COEF_W-1:0]     coef_zero,
	input  wire [sclr_pkg::COEF_W-1:0]     coef_one,
	input  wire [sclr_pkg::COEF_W-1:0]     coef_two,
	input  wire [sclr_pkg::COEF_W-1:0]     coef_three,
	input  wire [sclr_pkg::TPS_W-1:0]      ticks_per_second,
	output logic [sclr_pkg::TEMP_W-1:0]    temperature,
	output logic [sclr_pkg::TEMP_W-1:0]    rate,
	output logic                           rate_updated
);
	import sclr_pkg::*;

	localparam int CARRY_W = SAMPLE_BITS + 1;
	localparam int SUM_W   = LIMB_W + SAMPLE_BITS + 1;
	localparam logic [DIV_W-1:0] Q_POS_LIM = DIV_W'(SAT_MAX);
	localparam logic [DIV_W-1:0] Q_NEG_LIM = DIV_W'(SAT_MIN);

	logic [SAMPLE_BITS-1:0] x_q;
	logic [TICK_W-1:0]      tick_q;
	logic [ACC_W-1:0]       acc_q;
	logic [CARRY_W-1:0]     carry_q;
	logic [TEMP_W-1:0]      temp_q;
	logic                   neg_q;
	logic [MAG_W-1:0]       mag_q;
	logic [TICK_W-1:0]      delta_q;
	logic [DIV_W-1:0]       dvd_q;
	logic [MAG_W-1:0]       rem_q;
	logic [TEMP_W-1:0]      prev_q;
	logic [TICK_W-1:0]      last_tick_q;
	logic [TEMP_W-1:0]      held_rate_q;

	logic [COEF_W-1:0]              coef_add;
	logic [LIMB_W-1:0]              coef_sel;
	logic [CARRY_W-1:0]             carry_in;
	logic [LIMB_W+SAMPLE_BITS-1:0]  limb_prod;
	logic [SUM_W-1:0]               limb_sum;
	logic [TEMP_W-1:0]              temp_sat;
	logic [TEMP_W:0]                diff;
	logic [TEMP_W:0]                diff_abs;
	logic [PROD_W-1:0]              prod;
	logic [MAG_W:0]                 r1, r1m, r2, r2m;
	logic                           ge1, ge2;
	logic [TEMP_W-1:0]              rate_sat;

	assign status.tick_differs = (tick_q != last_tick_q);

	// coefficient added in the current Horner pass
	always_comb begin
		priority if (cmd.step == POLY_STEP_SQUARE) begin
			coef_add = coef_two;
		end else if (cmd.step == POLY_STEP_LINEAR) begin
			coef_add = coef_one;
		end else begin
			coef_add = coef_zero;
		end
	end

	// limb of the sign-extended coefficient
	always_comb begin
		unique case (cmd.limb)
			2'd0:    coef_sel = coef_add[LIMB_W-1:0];
			2'd1:    coef_sel = coef_add[COEF_W-1:LIMB_W];
			default: coef_sel = {LIMB_W{coef_add[COEF_W-1]}};
		endcase
	end

	// one limb of acc * x + coef per cycle
	assign carry_in  = (cmd.limb == '0) ? '0 : carry_q;
	assign limb_prod = acc_q[LIMB_W-1:0] * x_q;
	assign limb_sum  = SUM_W'(limb_prod) + SUM_W'(carry_in) + SUM_W'(coef_sel);

	// Q.48 to Q16.16 with saturation
	always_comb begin
		if ((&acc_q[ACC_W-1:63]) || !(|acc_q[ACC_W-1:63])) begin
			temp_sat = acc_q[63:32];
		end else begin
			temp_sat = acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX;
		end
	end

	// temperature difference magnitude
	assign diff     = {temp_q[TEMP_W-1], temp_q} - {prev_q[TEMP_W-1], prev_q};
	assign diff_abs = diff[TEMP_W] ? ((TEMP_W+1)'(0) - diff) : diff;
	assign prod     = mag_q * ticks_per_second;

	// two restoring divide steps per cycle
	always_comb begin
		r1  = {rem_q, dvd_q[DIV_W-1]};
		ge1 = (r1 >= {1'b0, delta_q});
		r1m = ge1 ? (r1 - {1'b0, delta_q}) : r1;
		r2  = {r1m[MAG_W-1:0], dvd_q[DIV_W-2]};
		ge2 = (r2 >= {1'b0, delta_q});
		r2m = ge2 ? (r2 - {1'b0, delta_q}) : r2;
	end

	// quotient to signed Q16.16 with saturation
	always_comb begin
		if (neg_q) begin
			rate_sat = (dvd_q > Q_NEG_LIM) ? SAT_MIN : (TEMP_W'(0) - dvd_q[TEMP_W-1:0]);
		end else begin
			rate_sat = (dvd_q > Q_POS_LIM) ? SAT_MAX : dvd_q[TEMP_W-1:0];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= adc_sample;
			tick_q  <= current_tick;
			acc_q   <= {{(ACC_W-COEF_W){coef_three[COEF_W-1]}}, coef_three};
			carry_q <= '0;
		end
		if (cmd.poly) begin
			acc_q   <= {limb_sum[LIMB_W-1:0], acc_q[ACC_W-1:LIMB_W]};
			carry_q <= limb_sum[SUM_W-1:LIMB_W];
		end
		if (cmd.sat) begin
			temp_q <= temp_sat;
		end
		if (cmd.diff) begin
			neg_q   <= diff[TEMP_W];
			mag_q   <= diff_abs[MAG_W-1:0];
			delta_q <= tick_q - last_tick_q;
		end
		if (cmd.mul) begin
			dvd_q <= DIV_W'(prod);
			rem_q <= '0;
		end
		if (cmd.div) begin
			dvd_q <= {dvd_q[DIV_W-3:0], ge1, ge2};
			rem_q <= r2m[MAG_W-1:0];
		end
	end

	// state kept from one sample to the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			last_tick_q <= '0;
			held_rate_q <= '0;
		end else if (cmd.finish) begin
			prev_q <= temp_q;
			if (status.tick_differs) begin
				last_tick_q <= tick_q;
				held_rate_q <= rate_sat;
			end
		end
	end

	// result fields
	assign temperature  = temp_q;
	assign rate_updated = status.tick_differs;
	assign rate         = status.tick_differs ? rate_sat : held_rate_q;

endmodule

`default_nettype wire

// ===== src/sensor_cubic_linearize_rate.sv =====
// A new input transaction is accepted only once the previous result has been taken into
// the output register, which waits while the output is stalled. The rate is recomputed
// only when the tick differs from that of the last rate update. The work per sample is the
// limb-serial 32 x SAMPLE_BITS Horner multiplier and, for a new rate, 30 radix-4 divide steps.
// Reset (arst_n low) clears state, coefficients to zero and ticks_per_second to 1000.
// ----------------------------------------------------------------------------
// sensor_cubic_linearize_rate
// Cubic linearisation of a converter sample with a saturated rate of change.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_cubic_linearize_rate #(
	parameter int SAMPLE_BITS = sclr_pkg::SAMPLE_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// tdata: adc_sample, current_tick, zero fill to whole bytes
	input  wire [((SAMPLE_BITS+sclr_pkg::TICK_W+7)/8)*8-1:0] s_axis_tdata,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata: temperature, rate
	output logic [2*sclr_pkg::TEMP_W-1:0]        m_axis_tdata,
	// tuser: rate_updated
	output logic                                 m_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire [sclr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [sclr_pkg::COEF_W-1:0]           cfg_data
);
	import sclr_pkg::*;

	logic [COEF_W-1:0] coef_zero_q, coef_one_q, coef_two_q, coef_three_q;
	logic [TPS_W-1:0]  tps_q;
	sclr_cmd_t         cmd;
	sclr_status_t      status;
	logic              out_free;
	logic [TEMP_W-1:0] temperature, rate;
	logic              rate_updated;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_zero_q  <= '0;
			coef_one_q   <= '0;
			coef_two_q   <= '0;
			coef_three_q <= '0;
			tps_q        <= TPS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COEF_ZERO:  coef_zero_q  <= cfg_data;
				REG_COEF_ONE:   coef_one_q   <= cfg_data;
				REG_COEF_TWO:   coef_two_q   <= cfg_data;
				REG_COEF_THREE: coef_three_q <= cfg_data;
				REG_TPS:        tps_q        <= cfg_data[TPS_W-1:0];
				default: ;
			endcase
		end
	end

	// output register
	assign out_free = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (cmd.finish) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			m_axis_tdata <= {rate, temperature};
			m_axis_tuser <= rate_updated;
		end
	end

	sclr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.status   (status),
		.cmd      (cmd)
	);

	sclr_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.adc_sample       (s_axis_tdata[SAMPLE_BITS-1:0]),
		.current_tick     (s_axis_tdata[SAMPLE_BITS+TICK_W-1:SAMPLE_BITS]),
		.coef_zero        (coef_zero_q),
		.coef_one         (coef_one_q),
		.coef_two         (coef_two_q),
		.coef_three       (coef_three_q),
		.ticks_per_second (tps_q),
		.temperature      (temperature),
		.rate             (rate),
		.rate_updated     (rate_updated)
	);

endmodule

`default_nettype wire
